// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers included by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lsn_pkg.sv -----
// ----------------------------------------------------------------------------
// lsn_pkg
// Types, constants and the row code mapping of the snow scanner.
// ----------------------------------------------------------------------------
package lsn_pkg;

    localparam logic       OP_SCAN  = 1'b0;
    localparam logic       OP_ANIM  = 1'b1;
    localparam logic [7:0] ROW_FULL = 8'hFF;

    typedef struct packed {
        logic       last;
        logic [2:0] row_code;
        logic [7:0] column_bits;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic clr;
    } t_mem_ctl;

    // row decoder code: bits 0 and 2 of the row index swapped
    function automatic logic [2:0] row_code_of(input logic [2:0] row);
        return {row[0], row[1], row[2]};
    endfunction

endpackage

// ----- design/lsn_frame_mem.sv -----
// ----------------------------------------------------------------------------
// lsn_frame_mem
// Frame store: one byte per row, one write and one registered read per cycle,
// per-row valid bits so that a cleared row reads as zero.
// ----------------------------------------------------------------------------
module lsn_frame_mem
    import lsn_pkg::*;
#(
    parameter int ROWS = 8,
    localparam int AW  = $clog2(ROWS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]      r_mem [ROWS];
    logic [ROWS-1:0] r_valid;
    logic [7:0]      r_rd_data;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_rd_addr];
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

// ----- design/lsn_out_q.sv -----
// ----------------------------------------------------------------------------
// lsn_out_q
// Two-entry result queue: a scan tick loads its blank and lit results at once.
// ----------------------------------------------------------------------------
module lsn_out_q
    import lsn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_blank,
    input  t_result i_lit,
    output logic    o_empty,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    logic [1:0] r_cnt;
    t_result    r_head;
    t_result    r_tail;
    logic       pop;

    assign pop = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= 2'd2;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_head <= i_blank;
            r_tail <= i_lit;
        end else if (pop) begin
            r_head <= r_tail;
        end
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_valid = !o_empty;
    assign o_head  = r_head;

endmodule

// ----- design/lsn_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsn_ctrl
// Sequencer: scan reads, full-frame check sweep and the bottom-up snow fall
// sweep over the frame store (read, modify, write back one row per cycle).
// ----------------------------------------------------------------------------
module lsn_ctrl
    import lsn_pkg::*;
#(
    parameter int ROWS = 8,
    localparam int AW  = $clog2(ROWS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic          i_op,
    input  logic [23:0]   i_rnd,
    output t_mem_ctl      o_mem,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    input  logic          i_q_empty,
    output logic          o_push,
    output t_result       o_blank,
    output t_result       o_lit
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_OUT = 3'd2;
    localparam logic [2:0] ST_CHK      = 3'd3;
    localparam logic [2:0] ST_CHK_END  = 3'd4;
    localparam logic [2:0] ST_FALL     = 3'd5;
    localparam logic [2:0] ST_FALL_END = 3'd6;
    localparam logic [2:0] ST_TOP      = 3'd7;

    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    logic [2:0]    r_state,  n_state;
    logic [AW-1:0] r_row,    n_row;
    logic [2:0]    r_code_prev, n_code_prev;
    logic          r_invert, n_invert;
    logic          r_dv,     n_dv;
    logic          r_full,   n_full;
    logic [AW-1:0] r_addr,   n_addr;
    logic [AW-1:0] r_daddr;
    logic [7:0]    r_carry,  n_carry;
    logic [7:0]    r_flakes;
    logic          accept;
    logic [7:0]    cols;

    assign o_tready = (r_state == ST_IDLE);
    assign accept   = i_tvalid & o_tready;
    assign cols     = i_rd_data ^ {8{r_invert}};

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_code_prev = r_code_prev;
        n_invert    = r_invert;
        n_dv        = 1'b0;
        n_full      = r_full;
        n_addr      = r_addr;
        n_carry     = r_carry;
        o_mem       = '0;
        o_wr_addr   = AW'(r_daddr + 1'b1);
        o_wr_data   = r_carry | i_rd_data;
        o_rd_addr   = r_row;
        o_push      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_SCAN) begin
                        n_code_prev = row_code_of(3'(r_row));
                        n_row       = (r_row == LAST_ROW) ? '0 : AW'(r_row + 1'b1);
                        n_state     = ST_SCAN_RD;
                    end else begin
                        n_addr  = '0;
                        n_full  = 1'b1;
                        n_state = ST_CHK;
                    end
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_OUT;
            end
            ST_SCAN_OUT: begin
                // read address stays on r_row, so the data holds while waiting
                if (i_q_empty) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CHK: begin
                o_rd_addr = r_addr;
                n_dv      = 1'b1;
                if (r_dv) begin
                    n_full = r_full & (i_rd_data == ROW_FULL);
                end
                if (r_addr == LAST_ROW) begin
                    n_state = ST_CHK_END;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            ST_CHK_END: begin
                if (r_full && (i_rd_data == ROW_FULL)) begin
                    o_mem.clr = 1'b1;
                    n_invert  = !r_invert;
                end
                n_addr  = LAST_ROW;
                n_state = ST_FALL;
            end
            ST_FALL, ST_FALL_END: begin
                // data of row d arrives: row d+1 takes the flakes from above,
                // the carry keeps what stays in row d
                if (r_dv || (r_state == ST_FALL_END)) begin
                    if (r_daddr == LAST_ROW) begin
                        n_carry = i_rd_data;
                    end else begin
                        o_mem.wr_en = 1'b1;
                        n_carry     = r_carry & i_rd_data;
                    end
                end
                if (r_state == ST_FALL) begin
                    o_rd_addr = r_addr;
                    n_dv      = 1'b1;
                    if (r_addr == '0) begin
                        n_state = ST_FALL_END;
                    end else begin
                        n_addr = AW'(r_addr - 1'b1);
                    end
                end else begin
                    n_state = ST_TOP;
                end
            end
            ST_TOP: begin
                o_mem.wr_en = 1'b1;
                o_wr_addr   = '0;
                o_wr_data   = r_carry | r_flakes;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_invert <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_invert <= n_invert;
            r_dv     <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_prev <= n_code_prev;
        r_full      <= n_full;
        r_addr      <= n_addr;
        r_daddr     <= o_rd_addr;
        r_carry     <= n_carry;
        if (accept) begin
            r_flakes <= i_rnd[7:0] & i_rnd[15:8] & i_rnd[23:16];
        end
    end

    assign o_blank = '{last: 1'b0, row_code: r_code_prev, column_bits: 8'h00};
    assign o_lit   = '{last: 1'b1, row_code: row_code_of(3'(r_row)), column_bits: cols};

endmodule

// ----- design/led_matrix_snow_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// led_matrix_snow_scanner_unit
// Monochrome LED matrix engine: row scan output and falling-snow animation
// over a frame store of ROWS row bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                | tuser / tlast
//  s_axis   | in  | [23:0] random_bits                   | tuser[0] operation
//  m_axis   | out | [7:0] column_bits, [10:8] row_code   | tlast last_of_run
//
//  Scan tick: the row is read in SCAN_RD and both results are queued from
//  SCAN_OUT, which waits until the previous pair has left the queue.
//  Animation tick: one frame-store read port access per row for the full
//  check and again for the fall sweep.
//  Reset clears the row counter, invert flag and row valid bits at once.
//  Output stalls never block input transfers, except a scan waiting to queue.
// ----------------------------------------------------------------------------
module led_matrix_snow_scanner_unit
    import lsn_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] random_bits
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] column_bits, [10:8] row_code, zero above
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(ROWS);

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          q_empty;
    logic          push;
    t_result       blank_res;
    t_result       lit_res;
    t_result       head;
    logic          s_xfer;
    logic          m_blank;
    logic          m_lit;

    lsn_frame_mem #(.ROWS(ROWS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lsn_ctrl #(.ROWS(ROWS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_op      (s_axis_tuser),
        .i_rnd     (s_axis_tdata),
        .o_mem     (mem_ctl),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .i_q_empty (q_empty),
        .o_push    (push),
        .o_blank   (blank_res),
        .o_lit     (lit_res)
    );

    lsn_out_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_blank (blank_res),
        .i_lit   (lit_res),
        .o_empty (q_empty),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {5'b0, head.row_code, head.column_bits};
    assign m_axis_tlast = head.last;

    assign s_xfer  = s_axis_tvalid & s_axis_tready;
    assign m_blank = m_axis_tvalid & !m_axis_tlast;
    assign m_lit   = m_axis_tvalid & m_axis_tlast;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_accept, s_xfer, !s_axis_tready, "transfer taken while busy")
    `ASSERT_SAME(a_blank_is_dark, m_blank, head.column_bits == 8'h00, "blank drives columns")
    `ASSERT_NEXT(a_lit_follows_blank, m_blank && m_axis_tready, m_lit, "no lit result")
    `ASSERT_SAME(a_push_into_empty, push, q_empty, "pair pushed over queued results")

endmodule

// ----- tb/sv/led_matrix_snow_scanner_checker.sv -----
// ----------------------------------------------------------------------------
// led_matrix_snow_scanner_checker
// Watches both stream channels of the snow scanner, keeps its own model of
// the frame, row counter and invert flag, and compares every output transfer
// with the oldest predicted scan result.
// ----------------------------------------------------------------------------
module led_matrix_snow_scanner_checker
    import lsn_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [23:0] random_bits
    input  logic        i_s_tuser,   // [0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] column_bits, [10:8] row_code, zero above
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  frame [ROWS];
    int unsigned scan_row;
    logic        inverted;
    t_result     scan_results [$];
    int          fail_total = 0;

    // row decoder wants bits 0 and 2 of the row index exchanged
    function automatic logic [2:0] decoder_code(input int unsigned row);
        logic [2:0] r;
        r = row[2:0];
        return {r[0], r[1], r[2]};
    endfunction

    task automatic clear_model();
        for (int i = 0; i < ROWS; i++) frame[i] = 8'h00;
        scan_row = 0;
        inverted = 1'b0;
        scan_results.delete();
    endtask

    task automatic predict_scan();
        t_result blank;
        t_result lit;
        logic [7:0] cols;
        blank.last        = 1'b0;
        blank.row_code    = decoder_code(scan_row);
        blank.column_bits = 8'h00;
        scan_results.push_back(blank);
        scan_row = (scan_row + 1) % ROWS;
        cols = frame[scan_row];
        if (inverted) cols = ~cols;
        lit.last        = 1'b1;
        lit.row_code    = decoder_code(scan_row);
        lit.column_bits = cols;
        scan_results.push_back(lit);
    endtask

    task automatic advance_snow(input logic [23:0] bits);
        logic       full;
        logic [7:0] moving;
        full = 1'b1;
        for (int i = 0; i < ROWS; i++) begin
            if (frame[i] != ROW_FULL) full = 1'b0;
        end
        if (full) begin
            for (int i = 0; i < ROWS; i++) frame[i] = 8'h00;
            inverted = ~inverted;
        end
        // bottom-up sweep so a flake drops one row at most
        for (int r = ROWS - 1; r >= 1; r--) begin
            moving       = frame[r-1] & ~frame[r];
            frame[r]     = frame[r] | moving;
            frame[r-1]   = frame[r-1] & ~moving;
        end
        frame[0] = frame[0] | (bits[7:0] & bits[15:8] & bits[23:16]);
    endtask

    task automatic check_result();
        t_result want;
        logic    bad;
        if (scan_results.size() == 0) begin
            fail_total++;
            $display("%0t: unexpected output transfer, expected none, actual %h last %b",
                     $time, i_m_tdata, i_m_tlast);
        end else begin
            want = scan_results.pop_front();
            bad  = (i_m_tdata[7:0] !== want.column_bits) ||
                   (i_m_tdata[10:8] !== want.row_code) ||
                   (i_m_tdata[15:11] !== 5'b0) ||
                   (i_m_tlast !== want.last);
            if (bad) begin
                fail_total++;
                $display(
                    "%0t: expected cols %h row %0d last %b, actual cols %h row %0d pad %h last %b",
                    $time, want.column_bits, want.row_code, want.last,
                    i_m_tdata[7:0], i_m_tdata[10:8], i_m_tdata[15:11], i_m_tlast);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            o_pending <= 0;
        end else begin
            // a result never comes from the input transfer of the same edge
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_ANIM) advance_snow(i_s_tdata);
                else predict_scan();
            end
            o_pending <= scan_results.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/sv/tb_led_matrix_snow_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// tb_led_matrix_snow_scanner_unit
// Drives scan and animation ticks into the snow scanner in random bursts,
// stalls the output side on changing patterns, and reports the checker's
// verdict once every predicted result has been seen.
// ----------------------------------------------------------------------------
module tb_led_matrix_snow_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lsn_pkg::*;

    localparam int ROWS        = 8;
    localparam int NUM_ITEMS   = 1600;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 2 * ROWS + 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [23:0] random_bits
    logic        s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] column_bits, [10:8] row_code, zero above
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    bit hold_req = 1'b0;
    int burst_left = 0;
    int items_sent = 0;

    led_matrix_snow_scanner_unit #(.ROWS(ROWS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    led_matrix_snow_scanner_checker #(.ROWS(ROWS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly full bytes so the frame fills up and the clear/invert path runs
    function automatic logic [23:0] dense_bits();
        logic [23:0] b;
        b = 24'hFF_FFFF;
        if ($urandom_range(0, 3) == 0) b[$urandom_range(0, 23)] = 1'b0;
        return b;
    endfunction

    // n must be at least one so tvalid sees a single assignment per step
    task automatic idle_for(input int n);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'($urandom);
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [23:0] bits);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) idle_for(gap);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        idle_for(1);
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        burst_left = 0;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        bit hold_taken;
        m_axis_tready <= 1'b0;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        phase      = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (phase % 4 == 0);
                    default: m_axis_tready <= (phase % 4 != 0);
                endcase
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_led_matrix_snow_scanner_unit NOT OK");
        $finish;
    end

    initial begin
        int style;
        int n;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'h0;
        s_axis_tuser  <= OP_SCAN;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty frame, flake spawning, fill, full-frame clear, row wrap
        send_item(OP_SCAN, 24'($urandom));
        send_item(OP_ANIM, 24'hFF_FFFF);
        send_item(OP_SCAN, 24'($urandom));
        send_item(OP_SCAN, 24'($urandom));
        send_item(OP_ANIM, 24'h00_FF00);
        send_item(OP_ANIM, 24'hA5_A5A5);
        send_item(OP_ANIM, 24'hFF_F00F);
        for (int i = 0; i < 8; i++) send_item(OP_ANIM, 24'hFF_FFFF);
        send_item(OP_ANIM, 24'h00_0000);
        for (int i = 0; i < 9; i++) send_item(OP_SCAN, 24'($urandom));
        drain();

        // output held off long enough for the block to back up its input
        hold_req   = 1'b1;
        burst_left = 100;
        for (int i = 0; i < 24; i++) send_item(OP_SCAN, 24'($urandom));
        drain();

        while (items_sent < NUM_ITEMS) begin
            style = $urandom_range(0, 9);
            if (style <= 3) begin
                n = $urandom_range(10, 40);
                for (int i = 0; i < n; i++)
                    send_item(($urandom_range(0, 2) == 0) ? OP_ANIM : OP_SCAN,
                              24'($urandom));
            end else if (style <= 6) begin
                n = $urandom_range(8, 14);
                for (int i = 0; i < n; i++) begin
                    send_item(OP_ANIM, dense_bits());
                    if ($urandom_range(0, 2) == 0) send_item(OP_SCAN, 24'($urandom));
                end
            end else if (style <= 8) begin
                n = $urandom_range(8, 20);
                for (int i = 0; i < n; i++) send_item(OP_SCAN, 24'($urandom));
            end else begin
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++) send_item(OP_ANIM, 24'($urandom & $urandom));
                drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_led_matrix_snow_scanner_unit OK");
        else
            $display("tb_led_matrix_snow_scanner_unit NOT OK");
        $finish;
    end

endmodule
